// ===== design/mtk_pkg.sv =====
// Package with shared types, constants and the Morse code table for the tone keyer.
package mtk_pkg;

    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    localparam logic [2:0] REG_DOT      = 3'd0;
    localparam logic [2:0] REG_OFFSET   = 3'd1;
    localparam logic [2:0] REG_TRANGE   = 3'd2;
    localparam logic [2:0] REG_TSTEP    = 3'd3;
    localparam logic [2:0] REG_NRANGE   = 3'd4;
    localparam logic [2:0] REG_NSTEP    = 3'd5;
    localparam logic [2:0] REG_MSGLEN   = 3'd6;
    localparam logic [2:0] REG_LOOP     = 3'd7;

    localparam logic [7:0] FIRST_CHAR = 8'h30;
    localparam logic [7:0] LAST_CHAR  = 8'h5A;

    // Queue entry between the front and the back.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] addr;
        logic [7:0] value;
    } t_cmd;

    // Table entry: pattern in bits 8..3, length in bits 2..0.
    function automatic logic [8:0] code_lookup(input logic [5:0] idx);
        logic [8:0] e;
        begin
            case (idx)
                6'd0:  e = {6'h1F, 3'd5};
                6'd1:  e = {6'h1E, 3'd5};
                6'd2:  e = {6'h1C, 3'd5};
                6'd3:  e = {6'h18, 3'd5};
                6'd4:  e = {6'h10, 3'd5};
                6'd5:  e = {6'h00, 3'd5};
                6'd6:  e = {6'h01, 3'd5};
                6'd7:  e = {6'h03, 3'd5};
                6'd8:  e = {6'h07, 3'd5};
                6'd9:  e = {6'h0F, 3'd5};
                6'd10: e = {6'h07, 3'd6};
                6'd13: e = {6'h11, 3'd5};
                6'd15: e = {6'h0C, 3'd6};
                6'd16: e = {6'h16, 3'd6};
                6'd17: e = {6'h02, 3'd2};
                6'd18: e = {6'h01, 3'd4};
                6'd19: e = {6'h05, 3'd4};
                6'd20: e = {6'h01, 3'd3};
                6'd21: e = {6'h00, 3'd1};
                6'd22: e = {6'h04, 3'd4};
                6'd23: e = {6'h03, 3'd3};
                6'd24: e = {6'h00, 3'd4};
                6'd25: e = {6'h00, 3'd2};
                6'd26: e = {6'h0E, 3'd4};
                6'd27: e = {6'h05, 3'd3};
                6'd28: e = {6'h02, 3'd4};
                6'd29: e = {6'h03, 3'd2};
                6'd30: e = {6'h01, 3'd2};
                6'd31: e = {6'h07, 3'd3};
                6'd32: e = {6'h06, 3'd4};
                6'd33: e = {6'h0B, 3'd4};
                6'd34: e = {6'h02, 3'd3};
                6'd35: e = {6'h00, 3'd3};
                6'd36: e = {6'h01, 3'd1};
                6'd37: e = {6'h04, 3'd3};
                6'd38: e = {6'h08, 3'd4};
                6'd39: e = {6'h06, 3'd3};
                6'd40: e = {6'h09, 3'd4};
                6'd41: e = {6'h0D, 3'd4};
                6'd42: e = {6'h03, 3'd4};
                default: e = 9'd0;
            endcase
            return e;
        end
    endfunction

endpackage

// ===== design/morse_tone_keyer_top.sv =====
// Top level of the Morse tone keyer: config registers, front queue and back end.
//  channel | direction | handshake          | payload
//  config  | in        | i_cfg_valid/ready  | i_cfg_index, i_cfg_data
//  input   | in        | i_valid/o_ready    | i_kind, i_char_addr, i_char_value
//  result  | out       | o_valid/i_ready    | o_sample, o_tone_on, o_message_done
// One tick per cycle while no result stalls; a result is registered through r_v1, r_v2
// and r_ov after its tick is accepted. A store write or restart holds off the next tick
// for the registered store read. Reset is synchronous; it clears the sequencer, the
// queue and loads register defaults. A stalled result holds the whole back pipeline.
module morse_tone_keyer_top #(
    parameter int MSG_DEPTH    = 256,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_char_addr,
    input  logic [7:0]  i_char_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_sample,
    output logic        o_tone_on,
    output logic        o_message_done
);
    import mtk_pkg::*;

    logic [15:0] r_dot, r_off, r_trng, r_nrng;
    logic [31:0] r_tstp, r_nstp;
    logic [8:0]  r_mlen;
    logic        r_loop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= 16'd100; r_off <= 16'd500; r_trng <= 16'd400;
            r_tstp <= 32'd85899346; r_nrng <= '0; r_nstp <= '0;
            r_mlen <= '0; r_loop <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DOT:    r_dot  <= i_cfg_data[15:0];
                REG_OFFSET: r_off  <= i_cfg_data[15:0];
                REG_TRANGE: r_trng <= i_cfg_data[15:0];
                REG_TSTEP:  r_tstp <= i_cfg_data;
                REG_NRANGE: r_nrng <= i_cfg_data[15:0];
                REG_NSTEP:  r_nstp <= i_cfg_data;
                REG_MSGLEN: r_mlen <= i_cfg_data[8:0];
                REG_LOOP:   r_loop <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    logic cmd_valid, cmd_ready;
    t_cmd cmd;

    mtk_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_char_addr(i_char_addr), .i_char_value(i_char_value),
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    mtk_back #(.MSG_DEPTH(MSG_DEPTH), .SINE_ENTRIES(SINE_ENTRIES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid),
        .o_cmd_ready(cmd_ready), .i_cmd(cmd),
        .i_dot_samples(r_dot), .i_level_offset(r_off), .i_tone_range(r_trng),
        .i_tone_step(r_tstp), .i_noise_range(r_nrng), .i_noise_step(r_nstp),
        .i_message_length(r_mlen), .i_loop_enable(r_loop),
        .o_valid(o_valid), .i_ready(i_ready), .o_sample(o_sample),
        .o_tone_on(o_tone_on), .o_message_done(o_message_done)
    );

    // A stalled result must hold its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample))
        else $error("result changed while stalled");

    // The sequencer never sounds a tone after a non-looping message ends.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_message_done |-> !o_tone_on)
        else $error("tone after message end");
endmodule

// ===== design/mtk_front.sv =====
// Front end: takes input beats and pushes them into a short command queue.
module mtk_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [1:0]     i_kind,
    input  logic [7:0]     i_char_addr,
    input  logic [7:0]     i_char_value,
    output logic           o_cmd_valid,
    input  logic           i_cmd_ready,
    output mtk_pkg::t_cmd  o_cmd
);
    import mtk_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    // Unused kind codes are dropped here and never reach the back end.
    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready && (i_kind != KIND_NONE);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{kind: i_kind, addr: i_char_addr, value: i_char_value};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== design/mtk_sine.sv =====
// Sine table of Q15 values in sign and magnitude form, one per phase step.
module mtk_sine #(
    parameter int SINE_ENTRIES = 1024
) (
    input  logic                            i_clk,
    input  logic [$clog2(SINE_ENTRIES)-1:0] i_k,
    output logic [15:0]                     o_mag,
    output logic                            o_neg
);
    function automatic logic [16:0] sine_of(input int k);
        logic [31:0] u, t, t2, p, s;
        logic [1:0]  q;
        begin
            u  = 32'((64'(k) * 64'd131072) / 64'(SINE_ENTRIES));
            q  = u[16:15];
            t  = {17'd0, u[14:0]};
            if (q[0]) t = 32'd32768 - t;
            t2 = (t * t) >> 15;
            p  = 32'd21167 - ((32'd2611 * t2) >> 15);
            p  = 32'd51472 - ((p * t2) >> 15);
            s  = (p * t) >> 15;
            if (s > 32'd32767) s = 32'd32767;
            return {q[1], s[15:0]};
        end
    endfunction

    logic [16:0] rom [SINE_ENTRIES];
    always_comb begin
        for (int i = 0; i < SINE_ENTRIES; i++) rom[i] = sine_of(i);
    end

    always_ff @(posedge i_clk) begin
        {o_neg, o_mag} <= rom[i_k];
    end
endmodule

// ===== design/mtk_back.sv =====
// Back end: message store, Morse sequencer and the sample pipeline.
module mtk_back #(
    parameter int MSG_DEPTH    = 256,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  mtk_pkg::t_cmd  i_cmd,
    input  logic [15:0]    i_dot_samples,
    input  logic [15:0]    i_level_offset,
    input  logic [15:0]    i_tone_range,
    input  logic [31:0]    i_tone_step,
    input  logic [15:0]    i_noise_range,
    input  logic [31:0]    i_noise_step,
    input  logic [8:0]     i_message_length,
    input  logic           i_loop_enable,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [15:0]    o_sample,
    output logic           o_tone_on,
    output logic           o_message_done
);
    import mtk_pkg::*;

    localparam int AW = $clog2(MSG_DEPTH);
    localparam int KW = $clog2(SINE_ENTRIES);

    // Pipeline: s0 sequencer (store read issued), s1 sine lookup, s2 scale, s3 sum.
    logic [7:0]  mem [MSG_DEPTH];
    logic [7:0]  r_char;

    logic [19:0] r_count, r_target;
    logic        r_in_space, r_finished, r_code_active;
    logic [5:0]  r_pattern;
    logic [2:0]  r_len, r_pos;
    logic [8:0]  r_idx;
    logic [31:0] r_tph, r_nph;
    // The character for r_idx is prefetched into r_char; r_fetch_pend is set while that read may be stale.
    logic        r_fetch_pend;

    logic stall, adv;
    logic r_v1, r_v2, r_ov;

    assign stall = r_ov && !i_ready;
    assign adv   = !stall;

    logic is_tick, tick_go, is_wr, is_rs;
    assign is_tick = i_cmd.kind == KIND_TICK;
    assign is_wr   = i_cmd.kind == KIND_WRITE;
    assign is_rs   = i_cmd.kind == KIND_RESTART;
    // A tick waits after reset, a store write or a restart so the store read is fresh.
    assign o_cmd_ready = adv && !r_fetch_pend;
    assign tick_go = i_cmd_valid && o_cmd_ready && is_tick;

    // Sequencer next state.
    logic [19:0] dot, n_target;
    logic        n_in_space, n_finished, n_active;
    logic [5:0]  n_pattern;
    logic [2:0]  n_len, n_pos;
    logic [8:0]  n_idx, len_c;
    logic        step;
    logic [8:0]  ent;
    logic [5:0]  cidx;
    logic [7:0]  cdiff;

    always_comb begin
        dot        = (i_dot_samples == 16'd0) ? 20'd1 : {4'd0, i_dot_samples};
        len_c      = ({23'd0, i_message_length} > 32'(MSG_DEPTH)) ? 9'(MSG_DEPTH)
                     : i_message_length;
        n_target   = r_target;
        n_in_space = r_in_space;
        n_finished = r_finished;
        n_active   = r_code_active;
        n_pattern  = r_pattern;
        n_len      = r_len;
        n_pos      = r_pos;
        n_idx      = r_idx;
        cdiff      = r_char - FIRST_CHAR;
        cidx       = cdiff[5:0];
        ent        = code_lookup(cidx);
        step       = !r_finished && (r_count == r_target);
        if (step) begin
            if (r_in_space) begin
                if (!r_code_active || r_pos >= r_len) begin
                    n_active = 1'b0;
                    n_target = 20'(dot * 20'd7);
                    if (r_idx >= len_c) begin
                        if (i_loop_enable) begin
                            n_idx = 9'd0;
                        end else begin
                            n_finished = 1'b1;
                        end
                    end else begin
                        n_idx = r_idx + 9'd1;
                        if (r_char >= FIRST_CHAR && r_char <= LAST_CHAR
                            && ent[2:0] != 3'd0) begin
                            n_active  = 1'b1;
                            n_len     = ent[2:0];
                            n_pattern = ent[8:3];
                            n_pos     = 3'd0;
                        end
                    end
                end
                if (n_active) begin
                    n_in_space = 1'b0;
                    n_target   = n_pattern[n_pos] ? 20'(dot * 20'd3) : dot;
                    n_pos      = n_pos + 3'd1;
                end else begin
                    n_in_space = 1'b1;
                end
            end else begin
                n_in_space = 1'b1;
                if (r_pos >= r_len) begin
                    n_target = 20'(dot * 20'd3);
                    n_active = 1'b0;
                end else begin
                    n_target = dot;
                end
            end
        end
    end

    logic [31:0] tph_use, nph_use;
    assign tph_use = step ? 32'd0 : r_tph;
    assign nph_use = step ? 32'd0 : r_nph;

    // Store write and prefetch read.
    logic [AW-1:0] rd_addr;
    logic          wr_go;
    assign wr_go   = i_cmd_valid && o_cmd_ready && is_wr && (32'(i_cmd.addr) < MSG_DEPTH);
    assign rd_addr = AW'(tick_go ? n_idx : r_idx);

    always_ff @(posedge i_clk) begin
        if (wr_go) mem[AW'(i_cmd.addr)] <= i_cmd.value;
        r_char <= mem[rd_addr];
    end

    // Stage 1 registers.
    logic          r_sp1, r_fin1;
    logic [KW-1:0] tk, nk;
    assign tk = tph_use[31 -: KW];
    assign nk = nph_use[31 -: KW];

    // Sine ROM outputs must hold during a stall; a stall freezes the address too.
    logic [KW-1:0] r_tk, r_nk;
    logic [KW-1:0] tk_in, nk_in;
    assign tk_in = adv ? tk : r_tk;
    assign nk_in = adv ? nk : r_nk;

    logic [15:0] tmag, nmag;
    logic        tneg, nneg;
    mtk_sine #(.SINE_ENTRIES(SINE_ENTRIES)) u_tsin (.i_clk(i_clk), .i_k(tk_in),
        .o_mag(tmag), .o_neg(tneg));
    mtk_sine #(.SINE_ENTRIES(SINE_ENTRIES)) u_nsin (.i_clk(i_clk), .i_k(nk_in),
        .o_mag(nmag), .o_neg(nneg));

    logic [31:0] r_tprod, r_nprod;
    logic        r_tneg2, r_nneg2, r_sp2, r_fin2;
    logic [16:0] tterm, nterm;
    logic signed [18:0] sum;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tk   <= tk;
            r_nk   <= nk;
            r_sp1  <= n_in_space;
            r_fin1 <= n_finished;
            r_tprod <= (i_tone_range == 16'd0 || r_sp1) ? 32'd0
                       : 32'(i_tone_range - 16'd1) * 32'(tmag);
            r_nprod <= (i_noise_range == 16'd0) ? 32'd0
                       : 32'(i_noise_range - 16'd1) * 32'(nmag);
            r_tneg2 <= tneg;
            r_nneg2 <= nneg;
            r_sp2   <= r_sp1;
            r_fin2  <= r_fin1;
            o_sample       <= (sum < 0) ? 16'd0 : (sum > 19'sd65535) ? 16'hFFFF : sum[15:0];
            o_tone_on      <= !r_sp2;
            o_message_done <= r_fin2;
        end
    end

    always_comb begin
        tterm = 17'((r_tprod + 32'd32768) >> 16);
        nterm = 17'((r_nprod + 32'd32768) >> 16);
        sum = $signed({3'd0, i_level_offset})
            + (r_tneg2 ? -$signed({2'd0, tterm}) : $signed({2'd0, tterm}))
            + (r_nneg2 ? -$signed({2'd0, nterm}) : $signed({2'd0, nterm}));
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0; r_target <= '0; r_in_space <= 1'b1; r_finished <= 1'b0;
            r_idx <= '0; r_code_active <= 1'b0; r_pattern <= '0; r_len <= '0;
            r_pos <= '0; r_tph <= '0; r_nph <= '0; r_fetch_pend <= 1'b1;
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_fetch_pend <= 1'b0;
            if (adv) begin
                r_v1 <= tick_go;
                r_v2 <= r_v1;
                r_ov <= r_v2;
            end
            if (i_cmd_valid && o_cmd_ready && is_rs) begin
                r_count <= '0; r_target <= '0; r_in_space <= 1'b1; r_finished <= 1'b0;
                r_idx <= '0; r_code_active <= 1'b0; r_pattern <= '0; r_len <= '0;
                r_pos <= '0; r_tph <= '0; r_nph <= '0; r_fetch_pend <= 1'b1;
            end else if (wr_go) begin
                r_fetch_pend <= 1'b1;
            end else if (tick_go) begin
                r_count <= step ? 20'd1 : r_count + 20'd1;
                r_target <= n_target; r_in_space <= n_in_space; r_finished <= n_finished;
                r_idx <= n_idx; r_code_active <= n_active; r_pattern <= n_pattern;
                r_len <= n_len; r_pos <= n_pos;
                r_tph <= tph_use + i_tone_step;
                r_nph <= nph_use + i_noise_step;
            end
        end
    end

    assign o_valid = r_ov;
endmodule

// ===== dv/mtk_checker.sv =====
// Checker for the Morse tone keyer: watches all three channels, predicts samples and compares.
module mtk_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_char_addr,
    input  logic [7:0]  i_char_value,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_sample,
    input  logic        i_tone_on,
    input  logic        i_message_done,
    output int          o_fails,
    output int          o_pending
);
    import mtk_pkg::*;

    localparam int STORE_DEPTH = 256;
    localparam int SINE_SIZE   = 1024;

    typedef struct {
        logic [15:0] sample;
        logic        tone_on;
        logic        done;
    } t_beat;

    // Dot/dash patterns for '0'..'Z': {pattern, length}, pattern bit i set means a dash.
    localparam logic [8:0] MORSE [0:42] = '{
        {6'h1F, 3'd5}, {6'h1E, 3'd5}, {6'h1C, 3'd5}, {6'h18, 3'd5}, {6'h10, 3'd5},
        {6'h00, 3'd5}, {6'h01, 3'd5}, {6'h03, 3'd5}, {6'h07, 3'd5}, {6'h0F, 3'd5},
        {6'h07, 3'd6}, 9'd0, 9'd0, {6'h11, 3'd5}, 9'd0,
        {6'h0C, 3'd6}, {6'h16, 3'd6},
        {6'h02, 3'd2}, {6'h01, 3'd4}, {6'h05, 3'd4}, {6'h01, 3'd3}, {6'h00, 3'd1},
        {6'h04, 3'd4}, {6'h03, 3'd3}, {6'h00, 3'd4}, {6'h00, 3'd2}, {6'h0E, 3'd4},
        {6'h05, 3'd3}, {6'h02, 3'd4}, {6'h03, 3'd2}, {6'h01, 3'd2}, {6'h07, 3'd3},
        {6'h06, 3'd4}, {6'h0B, 3'd4}, {6'h02, 3'd3}, {6'h00, 3'd3}, {6'h01, 3'd1},
        {6'h04, 3'd3}, {6'h08, 3'd4}, {6'h06, 3'd3}, {6'h09, 3'd4}, {6'h0D, 3'd4},
        {6'h03, 3'd4}
    };

    logic [15:0] dot_len, offset, tone_span, noise_span;
    logic [31:0] tone_inc, noise_inc;
    logic [8:0]  msg_len;
    logic        looping;

    logic [7:0]  text [STORE_DEPTH];
    logic [19:0] elem_cnt, elem_end;
    logic        spacing, halted, char_live;
    logic [8:0]  char_pos;
    logic [5:0]  pattern;
    logic [2:0]  pat_len, pat_pos;
    logic [31:0] tone_ph, noise_ph;

    t_beat expected_beats [$];

    assign o_pending = expected_beats.size();

    function automatic longint sine_q15(logic [31:0] ph);
        longint unsigned k, u, q, t, t2, p, s;
        k = (longint'(ph) * SINE_SIZE) >> 32;
        u = (k * 131072) / SINE_SIZE;
        q = (u >> 15) & 3;
        t = u & 32767;
        if (q & 1) t = 32768 - t;
        t2 = (t * t) >> 15;
        p = 21167 - ((2611 * t2) >> 15);
        p = 51472 - ((p * t2) >> 15);
        s = (p * t) >> 15;
        if (s > 32767) s = 32767;
        return (q >= 2) ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint sine_term(logic [15:0] span, logic [31:0] ph);
        longint s, mag;
        if (span == 0) return 0;
        s = sine_q15(ph);
        mag = (longint'(span - 1) * (s < 0 ? -s : s) + 32768) >>> 16;
        return s < 0 ? -mag : mag;
    endfunction

    task automatic restart_play();
        elem_cnt = 0; elem_end = 0; spacing = 1; halted = 0; char_pos = 0;
        char_live = 0; pattern = 0; pat_len = 0; pat_pos = 0;
        tone_ph = 0; noise_ph = 0;
    endtask

    task automatic fetch_char(logic [19:0] dot);
        int unsigned len;
        logic [7:0]  c;
        logic [8:0]  e;
        len = (32'(msg_len) > STORE_DEPTH) ? STORE_DEPTH : 32'(msg_len);
        char_live = 0;
        elem_end = 20'(7 * dot);
        if (char_pos >= len) begin
            if (looping) char_pos = 0;
            else halted = 1;
            return;
        end
        c = text[char_pos];
        char_pos++;
        if (c >= FIRST_CHAR && c <= LAST_CHAR) begin
            e = MORSE[c - FIRST_CHAR];
            if (e[2:0] != 0) begin
                char_live = 1;
                pat_len = e[2:0];
                pattern = e[8:3];
                pat_pos = 0;
            end
        end
    endtask

    task automatic next_element();
        logic [19:0] dot;
        dot = (dot_len == 0) ? 20'd1 : 20'(dot_len);
        elem_cnt = 0;
        tone_ph = 0;
        noise_ph = 0;
        if (spacing) begin
            if (!char_live || pat_pos >= pat_len) fetch_char(dot);
            if (char_live) begin
                spacing = 0;
                elem_end = pattern[pat_pos] ? 20'(3 * dot) : dot;
                pat_pos = 3'(pat_pos + 1);
            end
        end else begin
            spacing = 1;
            if (pat_pos >= pat_len) begin
                elem_end = 20'(3 * dot);
                char_live = 0;
            end else begin
                elem_end = dot;
            end
        end
    endtask

    function automatic t_beat tick_sample();
        t_beat  b;
        longint sum;
        sum = offset;
        if (!spacing) sum += sine_term(tone_span, tone_ph);
        sum += sine_term(noise_span, noise_ph);
        if (sum < 0) sum = 0;
        if (sum > 65535) sum = 65535;
        b.sample = sum[15:0];
        b.tone_on = !spacing;
        b.done = halted;
        return b;
    endfunction

    always @(posedge i_clk) begin
        t_beat b, got;
        if (!i_rst_n) begin
            dot_len = 100; offset = 500; tone_span = 400; tone_inc = 32'd85899346;
            noise_span = 0; noise_inc = 0; msg_len = 0; looping = 0;
            restart_play();
            expected_beats.delete();
            o_fails <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_DOT:    dot_len = i_cfg_data[15:0];
                    REG_OFFSET: offset = i_cfg_data[15:0];
                    REG_TRANGE: tone_span = i_cfg_data[15:0];
                    REG_TSTEP:  tone_inc = i_cfg_data;
                    REG_NRANGE: noise_span = i_cfg_data[15:0];
                    REG_NSTEP:  noise_inc = i_cfg_data;
                    REG_MSGLEN: msg_len = i_cfg_data[8:0];
                    REG_LOOP:   looping = i_cfg_data[0];
                endcase
            end
            if (i_valid && i_ready) begin
                case (i_kind)
                    KIND_WRITE:   text[i_char_addr] = i_char_value;
                    KIND_RESTART: restart_play();
                    KIND_TICK: begin
                        if (!halted && elem_cnt == elem_end) next_element();
                        expected_beats.push_back(tick_sample());
                        elem_cnt = 20'(elem_cnt + 1);
                        tone_ph += tone_inc;
                        noise_ph += noise_inc;
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got.sample = i_sample;
                got.tone_on = i_tone_on;
                got.done = i_message_done;
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected beat sample=%0d tone_on=%0b done=%0b",
                             $time, got.sample, got.tone_on, got.done);
                    o_fails <= o_fails + 1;
                end else begin
                    b = expected_beats.pop_front();
                    if (b.sample !== got.sample || b.tone_on !== got.tone_on
                            || b.done !== got.done) begin
                        $display({"%0t: mismatch expected sample=%0d tone_on=%0b done=%0b,",
                                  " got sample=%0d tone_on=%0b done=%0b"},
                                 $time, b.sample, b.tone_on, b.done,
                                 got.sample, got.tone_on, got.done);
                        o_fails <= o_fails + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the Morse tone keyer: stimulus, back-pressure and verdict.
module tb;
    import mtk_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 0;
    logic [1:0]  i_kind = '0;
    logic [7:0]  i_char_addr = '0;
    logic [7:0]  i_char_value = '0;
    logic        i_ready = 0;
    logic        o_cfg_ready, o_ready, o_valid, o_tone_on, o_message_done;
    logic [15:0] o_sample;
    int          fails, pending, cycles = 0, stall = 0;
    bit          steady = 0;

    morse_tone_keyer_top uut (.*);

    mtk_checker u_chk (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .i_valid, .i_ready(o_ready), .i_kind, .i_char_addr,
        .i_char_value, .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_sample(o_sample), .i_tone_on(o_tone_on), .i_message_done(o_message_done),
        .o_fails(fails), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Result side stalls in bursts, none once the run goes steady.
    always @(posedge i_clk) begin
        if (steady || !i_rst_n) begin
            i_ready <= 1;
        end else if (stall > 0) begin
            stall <= stall - 1;
            i_ready <= 0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall <= $urandom_range(0, 12);
            i_ready <= 0;
        end else begin
            i_ready <= 1;
        end
    end

    task automatic send(logic [1:0] kind, logic [7:0] addr, logic [7:0] value);
        int gap;
        gap = (!steady && $urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_kind <= kind;
        i_char_addr <= addr;
        i_char_value <= value;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Leaves the channel valid so writes can follow back to back; the caller drops it.
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Holds the sender off until every sample is back and the pipeline is empty.
    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0: return 8'h20;
            1: return 8'($urandom_range(0, 255));
            2: return 8'h3B + 8'($urandom_range(0, 1)) + 8'($urandom_range(0, 1));
            default: return 8'($urandom_range(8'h30, 8'h5A));
        endcase
    endfunction

    function automatic logic [15:0] pick_span();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            default: return 16'($urandom_range(2, 30000));
        endcase
    endfunction

    initial begin
        int phase, n, ticks;
        logic [15:0] dot;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Fill the whole store so no unwritten entry is ever played.
        for (int a = 0; a < 256; a++) send(KIND_WRITE, a[7:0], pick_char());
        send(KIND_WRITE, 8'd255, 8'hFF);
        send(KIND_WRITE, 8'd0, 8'h00);
        send(KIND_NONE, 8'hFF, 8'hFF);
        for (int i = 0; i < 6; i++) send(KIND_TICK, 8'd0, 8'd0);
        send(KIND_RESTART, 8'd0, 8'd0);
        for (int i = 0; i < 6; i++) send(KIND_TICK, 8'd0, 8'd0);
        drain();

        for (phase = 0; phase < 11; phase++) begin
            case (phase)
                0: dot = 16'd0;
                1: dot = 16'd1;
                3: dot = 16'hFFFF;
                default: dot = 16'($urandom_range(1, 4));
            endcase
            write_reg(REG_DOT, {16'($urandom), dot});
            write_reg(REG_OFFSET, phase == 2 ? 32'hFFFF : phase == 4 ? 32'h0 : $urandom);
            write_reg(REG_TRANGE, {16'($urandom), pick_span()});
            write_reg(REG_TSTEP, phase == 5 ? 32'hFFFFFFFF : phase == 6 ? 32'h0 : $urandom);
            write_reg(REG_NRANGE, {16'($urandom), pick_span()});
            write_reg(REG_NSTEP, phase == 5 ? 32'hFFFFFFFF : $urandom);
            case (phase)
                2: n = 0;
                5: n = 256;
                6: n = 300;
                7: n = 511;
                default: n = $urandom_range(1, 12);
            endcase
            write_reg(REG_MSGLEN, ($urandom & 32'hFFFFFE00) | 32'(n));
            write_reg(REG_LOOP, ($urandom & 32'hFFFFFFFE) | 32'(phase % 2));
            i_cfg_valid <= 0;
            if ($urandom_range(0, 2) != 0) send(KIND_RESTART, 8'($urandom), 8'($urandom));

            steady = (phase == 10);
            ticks = (phase == 3) ? 20 : 120;
            for (int i = 0; i < ticks; i++) begin
                case ($urandom_range(0, 39))
                    0, 1, 2: send(KIND_WRITE, 8'($urandom), pick_char());
                    3:       send(KIND_RESTART, 8'($urandom), 8'($urandom));
                    4:       send(KIND_NONE, 8'($urandom), 8'($urandom));
                    default: send(KIND_TICK, 8'($urandom), 8'($urandom));
                endcase
            end
            drain();
        end

        if (fails == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
